// ===== rtl/epcm_pkg.sv =====
// shared constants, item type and function codes for the stereo pcm mixer
package epcm_pkg;

  localparam int NUM_VOICES   = 8;
  localparam int CHUNK_FRAMES = 315;
  localparam int CHUNK_BYTES  = 2 * CHUNK_FRAMES;

  localparam int VOICE_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int FRAME_W = $clog2(CHUNK_FRAMES + 1);
  localparam int CH_W    = 3;
  localparam int SMP_W   = 8;
  localparam int CLIP_W  = 24;
  localparam int VOL_W   = 7;
  localparam int SEP_W   = 8;
  localparam int MASK_W  = 8;
  localparam int GAIN_W  = VOL_W + SEP_W;
  localparam int PROD_W  = 24;
  localparam int SUM_W   = 28;

  localparam int SEP_MAX    = 254;
  localparam int SAMPLE_MID = 128;
  localparam int DIVISOR    = 127 * 127;

  // scaler: eight quotient bits, magnitude clamped at 256 divisors
  localparam int QUOT_W  = 8;
  localparam int SAT_MAG = 256 * DIVISOR;
  localparam int REM_W   = $clog2(SAT_MAG);
  localparam int RECIP   = (1 << REM_W) / DIVISOR;
  localparam int RECIP_W = $clog2(RECIP + 1);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_PAIR   = 2'd0,
    FUNC_START  = 2'd1,
    FUNC_STOP   = 2'd2,
    FUNC_UPDATE = 2'd3
  } func_t;

  typedef struct packed {
    func_t                    func;
    logic                     known;
    logic [CH_W-1:0]          channel;
    logic signed [SMP_W:0]    left;
    logic signed [SMP_W:0]    right;
    logic                     last;
    logic [CLIP_W-1:0]        clip;
    logic [VOL_W-1:0]         volume;
    logic [SEP_W-1:0]         separation;
  } item_t;

endpackage

// ===== rtl/epcm_scale.sv =====
// divide by 127*127 via reciprocal multiply and one correction, saturate to an 8-bit sample
module epcm_scale (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [epcm_pkg::SUM_W-1:0] sum,
  output logic                              done,
  output logic [epcm_pkg::SMP_W-1:0]        sample
);
  import epcm_pkg::*;

  logic                     busy;
  logic                     neg;
  logic                     over;
  logic [REM_W-1:0]         rem;
  logic [QUOT_W-1:0]        est;
  logic [QUOT_W-1:0]        quot;
  logic [SUM_W-1:0]         mag;
  logic [REM_W+RECIP_W-1:0] est_full;
  logic [REM_W-1:0]         resid;
  logic [QUOT_W-1:0]        whole;

  assign mag = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);

  // the estimate is never above the true quotient and at most one below it
  assign est_full = (REM_W+RECIP_W)'(mag[REM_W-1:0]) * (REM_W+RECIP_W)'(RECIP);
  assign resid    = rem - REM_W'(est) * REM_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= sum[SUM_W-1];
      over <= mag >= SUM_W'(SAT_MAG);
      rem  <= mag[REM_W-1:0];
      est  <= est_full[REM_W +: QUOT_W];
    end
    if (busy) begin
      quot <= (resid >= REM_W'(DIVISOR)) ? est + 1'b1 : est;
    end
  end

  // truncation toward zero falls out of dividing the magnitude
  assign whole = over ? '1 : quot;

  always_comb begin
    if (neg) begin
      sample = (whole >= QUOT_W'(SAMPLE_MID)) ? '0 : SMP_W'(SAMPLE_MID) - SMP_W'(whole);
    end else begin
      sample = (whole >= QUOT_W'(SAMPLE_MID - 1)) ? '1 : SMP_W'(SAMPLE_MID) + SMP_W'(whole);
    end
  end

endmodule

// ===== rtl/epcm_front.sv =====
// input side: decodes items and holds them in a short queue for the mixing engine
module epcm_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [1:0]                         func,
  input  logic [epcm_pkg::CH_W-1:0]          channel,
  input  logic [epcm_pkg::SMP_W-1:0]         left_sample,
  input  logic [epcm_pkg::SMP_W-1:0]         right_sample,
  input  logic                               last_channel,
  input  logic [epcm_pkg::CLIP_W-1:0]        clip_length,
  input  logic [epcm_pkg::VOL_W-1:0]         volume,
  input  logic [epcm_pkg::SEP_W-1:0]         separation,
  output epcm_pkg::item_t                    head,
  output logic                               head_valid,
  input  logic                               take
);
  import epcm_pkg::*;

  item_t             slot [QUEUE_DEPTH];
  item_t             incoming;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              wr_en;
  logic              rd_en;

  always_comb begin
    incoming.func       = func_t'(func);
    incoming.known      = 32'(channel) < 32'(NUM_VOICES);
    incoming.channel    = channel;
    incoming.left       = {1'b0, left_sample} - (SMP_W+1)'(SAMPLE_MID);
    incoming.right      = {1'b0, right_sample} - (SMP_W+1)'(SAMPLE_MID);
    incoming.last       = last_channel;
    incoming.clip       = clip_length;
    incoming.volume     = volume;
    incoming.separation = (separation > SEP_W'(SEP_MAX)) ? SEP_W'(SEP_MAX) : separation;
  end

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slot[rd_ptr];
  assign wr_en      = push && !full;
  assign rd_en      = take && head_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(wr_en) - QCNT_W'(rd_en);
    end
  end

endmodule

// ===== rtl/epcm_back.sv =====
// mixing engine: voice state, gain and accumulate, frame close and result register
module epcm_back (
  input  logic                        clk,
  input  logic                        rst,
  input  epcm_pkg::item_t             head,
  input  logic                        head_valid,
  output logic                        take,
  output logic                        empty,
  input  logic                        pop,
  output logic [epcm_pkg::SMP_W-1:0]  left_out,
  output logic [epcm_pkg::SMP_W-1:0]  right_out,
  output logic                        chunk_end,
  output logic [epcm_pkg::MASK_W-1:0] active_mask
);
  import epcm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                  state;
  logic [NUM_VOICES-1:0]   active;
  logic [CLIP_W-1:0]       remaining  [NUM_VOICES];
  logic [VOL_W-1:0]        vol_store  [NUM_VOICES];
  logic [SEP_W-1:0]        sep_store  [NUM_VOICES];
  logic signed [SUM_W-1:0] left_sum;
  logic signed [SUM_W-1:0] right_sum;
  logic [FRAME_W-1:0]      frame_pos;

  logic [VOICE_W-1:0]      idx;
  logic                    hit_now;
  logic [GAIN_W-1:0]       left_gain_now;
  logic [GAIN_W-1:0]       right_gain_now;

  logic                    hit;
  logic                    last;
  logic signed [SMP_W:0]   left_smp;
  logic signed [SMP_W:0]   right_smp;
  logic [GAIN_W-1:0]       left_gain;
  logic [GAIN_W-1:0]       right_gain;
  logic signed [PROD_W-1:0] left_prod;
  logic signed [PROD_W-1:0] right_prod;
  logic signed [SUM_W-1:0] left_sum_next;
  logic signed [SUM_W-1:0] right_sum_next;

  logic                    frame_end;
  logic [NUM_VOICES-1:0]   close_active;
  logic [MASK_W-1:0]       close_mask;
  logic                    pend_end;
  logic [MASK_W-1:0]       pend_mask;

  logic                    scale_start;
  logic                    left_done;
  logic                    right_done;
  logic [SMP_W-1:0]        left_scaled;
  logic [SMP_W-1:0]        right_scaled;
  logic                    out_valid;
  logic                    closing;

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] acc,
                                                      input logic signed [PROD_W-1:0] p);
    logic signed [SUM_W:0] wide;
    wide = (SUM_W+1)'(acc) + (SUM_W+1)'(p);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      sat_add = wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = wide[SUM_W-1:0];
    end
  endfunction

  assign idx  = VOICE_W'(head.channel);
  assign take = (state == ST_IDLE) && head_valid;

  // a pair counts while the frame lies inside the remaining clip
  always_comb begin
    hit_now        = head.known && active[idx] &&
                     ((CLIP_W-1)'(frame_pos) < remaining[idx][CLIP_W-1:1]);
    left_gain_now  = GAIN_W'(vol_store[idx]) * GAIN_W'(sep_store[idx]);
    right_gain_now = GAIN_W'(vol_store[idx]) * GAIN_W'(SEP_W'(SEP_MAX) - sep_store[idx]);
  end

  assign left_sum_next  = hit ? sat_add(left_sum, left_prod) : left_sum;
  assign right_sum_next = hit ? sat_add(right_sum, right_prod) : right_sum;

  assign frame_end = frame_pos >= FRAME_W'(CHUNK_FRAMES - 1);
  assign closing   = (state == ST_ACC) && last;

  always_comb begin
    close_mask = '0;
    for (int v = 0; v < NUM_VOICES; v++) begin
      close_active[v] = active[v] && !(frame_end && remaining[v] <= CLIP_W'(CHUNK_BYTES));
    end
    for (int v = 0; v < MASK_W; v++) begin
      if (v < NUM_VOICES) begin
        close_mask[v] = close_active[v];
      end
    end
  end

  assign scale_start = closing;

  epcm_scale u_scale_left (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .sum    (left_sum_next),
    .done   (left_done),
    .sample (left_scaled)
  );

  epcm_scale u_scale_right (
    .clk    (clk),
    .rst    (rst),
    .start  (scale_start),
    .sum    (right_sum_next),
    .done   (right_done),
    .sample (right_scaled)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (head_valid && head.func == FUNC_PAIR) begin
            state <= ST_MUL;
          end
        end
        ST_MUL:  state <= ST_ACC;
        ST_ACC:  state <= last ? ST_DIV : ST_IDLE;
        ST_DIV: begin
          if (left_done && right_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // pair datapath
  always_ff @(posedge clk) begin
    if (take) begin
      hit        <= hit_now;
      last       <= head.last;
      left_smp   <= head.left;
      right_smp  <= head.right;
      left_gain  <= left_gain_now;
      right_gain <= right_gain_now;
    end
    if (state == ST_MUL) begin
      left_prod  <= PROD_W'(left_smp * $signed({1'b0, left_gain}));
      right_prod <= PROD_W'(right_smp * $signed({1'b0, right_gain}));
    end
    if (closing) begin
      pend_end  <= frame_end;
      pend_mask <= close_mask;
    end
  end

  // voice state, sums and frame counter
  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= '0;
      left_sum  <= '0;
      right_sum <= '0;
      frame_pos <= '0;
      for (int v = 0; v < NUM_VOICES; v++) begin
        remaining[v] <= '0;
        vol_store[v] <= '0;
        sep_store[v] <= '0;
      end
    end else begin
      if (take && head.known) begin
        unique case (head.func)
          FUNC_START: begin
            remaining[idx] <= head.clip;
            vol_store[idx] <= head.volume;
            sep_store[idx] <= head.separation;
            active[idx]    <= 1'b1;
          end
          FUNC_STOP:   active[idx] <= 1'b0;
          FUNC_UPDATE: begin
            vol_store[idx] <= head.volume;
            sep_store[idx] <= head.separation;
          end
          FUNC_PAIR: ;
          default: ;
        endcase
      end
      if (state == ST_ACC) begin
        if (last) begin
          left_sum  <= '0;
          right_sum <= '0;
          active    <= close_active;
          frame_pos <= frame_end ? '0 : frame_pos + 1'b1;
          if (frame_end) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
              if (active[v]) begin
                remaining[v] <= close_active[v] ? remaining[v] - CLIP_W'(CHUNK_BYTES) : '0;
              end
            end
          end
        end else begin
          left_sum  <= left_sum_next;
          right_sum <= right_sum_next;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && !out_valid) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && !out_valid) begin
      left_out    <= left_scaled;
      right_out   <= right_scaled;
      chunk_end   <= pend_end;
      active_mask <= pend_mask;
    end
  end

  assign empty = !out_valid;

endmodule

// ===== rtl/eight_channel_stereo_pcm_mixer_core.sv =====
// Stereo PCM mixer for up to eight voices of unsigned 8-bit audio, mixed in chunks of
// 315 frames. Items enter through a two-beat queue; the mixing engine applies start, stop
// and update items as it takes them, and runs a sample pair through lookup and gain, multiply
// and accumulate. The pair that closes a frame adds the scaling of both sums by 1/(127*127),
// a reciprocal multiply and one correcting subtract, before its result reaches the output
// register, which holds one beat until popped while the input queue keeps taking items
// until it is full.
module eight_channel_stereo_pcm_mixer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    func,
  input  logic [epcm_pkg::CH_W-1:0]     channel,
  input  logic [epcm_pkg::SMP_W-1:0]    left_sample,
  input  logic [epcm_pkg::SMP_W-1:0]    right_sample,
  input  logic                          last_channel,
  input  logic [epcm_pkg::CLIP_W-1:0]   clip_length,
  input  logic [epcm_pkg::VOL_W-1:0]    volume,
  input  logic [epcm_pkg::SEP_W-1:0]    separation,
  output logic                          empty,
  input  logic                          pop,
  output logic [epcm_pkg::SMP_W-1:0]    left_out,
  output logic [epcm_pkg::SMP_W-1:0]    right_out,
  output logic                          chunk_end,
  output logic [epcm_pkg::MASK_W-1:0]   active_mask
);
  import epcm_pkg::*;

  item_t head;
  logic  head_valid;
  logic  take;

  epcm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .channel      (channel),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_channel (last_channel),
    .clip_length  (clip_length),
    .volume       (volume),
    .separation   (separation),
    .head         (head),
    .head_valid   (head_valid),
    .take         (take)
  );

  epcm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (head_valid),
    .take        (take),
    .empty       (empty),
    .pop         (pop),
    .left_out    (left_out),
    .right_out   (right_out),
    .chunk_end   (chunk_end),
    .active_mask (active_mask)
  );

endmodule

// ===== test/tb_top.sv =====
// testbench for the eight-voice stereo pcm mixer core: random and directed items, frame checker
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import epcm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 500;
  localparam longint ACC_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
  localparam longint ACC_MIN = -(longint'(1) <<< (SUM_W - 1));

  typedef struct {
    func_t             func;
    logic [CH_W-1:0]   channel;
    logic [SMP_W-1:0]  left_sample;
    logic [SMP_W-1:0]  right_sample;
    logic              last_channel;
    logic [CLIP_W-1:0] clip_length;
    logic [VOL_W-1:0]  volume;
    logic [SEP_W-1:0]  separation;
  } mix_item_t;

  typedef struct {
    logic [SMP_W-1:0]  left_out;
    logic [SMP_W-1:0]  right_out;
    logic              chunk_end;
    logic [MASK_W-1:0] active_mask;
  } mix_frame_t;

  class mixer_scoreboard;
    bit                voice_on   [NUM_VOICES];
    logic [CLIP_W-1:0] voice_left [NUM_VOICES];
    logic [VOL_W-1:0]  voice_vol  [NUM_VOICES];
    logic [SEP_W-1:0]  voice_sep  [NUM_VOICES];
    longint            left_acc;
    longint            right_acc;
    int unsigned       frame_idx;
    mix_frame_t        frames_due [$];
    int                fails;

    function new();
      for (int v = 0; v < NUM_VOICES; v++) begin
        voice_on[v]   = 1'b0;
        voice_left[v] = '0;
        voice_vol[v]  = '0;
        voice_sep[v]  = '0;
      end
      left_acc   = 0;
      right_acc  = 0;
      frame_idx  = 0;
      fails      = 0;
    endfunction

    function longint clamp_acc(longint v);
      if (v > ACC_MAX) return ACC_MAX;
      if (v < ACC_MIN) return ACC_MIN;
      return v;
    endfunction

    // divide truncating toward zero, clamp to signed 8 bits, shift to unsigned
    function logic [SMP_W-1:0] scale_sum(longint acc);
      longint q;
      q = acc / DIVISOR;
      if (q < -128) q = -128;
      if (q > 127) q = 127;
      return SMP_W'(q + SAMPLE_MID);
    endfunction

    function void close_frame();
      mix_frame_t f;
      bit at_end;
      at_end = frame_idx >= CHUNK_FRAMES - 1;
      if (at_end) begin
        for (int v = 0; v < NUM_VOICES; v++) begin
          if (voice_on[v]) begin
            if (voice_left[v] > CHUNK_BYTES) begin
              voice_left[v] = CLIP_W'(voice_left[v] - CHUNK_BYTES);
            end else begin
              voice_left[v] = '0;
              voice_on[v]   = 1'b0;
            end
          end
        end
        frame_idx = 0;
      end else begin
        frame_idx++;
      end
      f.active_mask = '0;
      for (int v = 0; v < NUM_VOICES && v < MASK_W; v++) f.active_mask[v] = voice_on[v];
      f.left_out  = scale_sum(left_acc);
      f.right_out = scale_sum(right_acc);
      f.chunk_end = at_end;
      frames_due.push_back(f);
      left_acc  = 0;
      right_acc = 0;
    endfunction

    function void note_item(mix_item_t it);
      int unsigned       ch;
      int unsigned       bound;
      logic [SEP_W-1:0]  sep;
      longint            lg;
      longint            rg;
      ch  = 32'(it.channel);
      sep = (it.separation > SEP_MAX) ? SEP_W'(SEP_MAX) : it.separation;
      case (it.func)
        FUNC_START: begin
          if (ch < NUM_VOICES) begin
            voice_left[ch] = it.clip_length;
            voice_vol[ch]  = it.volume;
            voice_sep[ch]  = sep;
            voice_on[ch]   = 1'b1;
          end
        end
        FUNC_STOP: begin
          if (ch < NUM_VOICES) voice_on[ch] = 1'b0;
        end
        FUNC_UPDATE: begin
          if (ch < NUM_VOICES) begin
            voice_vol[ch] = it.volume;
            voice_sep[ch] = sep;
          end
        end
        default: begin
          if (ch < NUM_VOICES && voice_on[ch]) begin
            // a voice only plays while its frame lies inside the clip
            bound = 32'(voice_left[ch] >> 1);
            if (bound > CHUNK_FRAMES) bound = CHUNK_FRAMES;
            if (frame_idx < bound) begin
              lg = longint'(voice_vol[ch]) * longint'(voice_sep[ch]);
              rg = longint'(voice_vol[ch]) * (SEP_MAX - longint'(voice_sep[ch]));
              left_acc  = clamp_acc(left_acc + (longint'(it.left_sample) - SAMPLE_MID) * lg);
              right_acc = clamp_acc(right_acc + (longint'(it.right_sample) - SAMPLE_MID) * rg);
            end
          end
          if (it.last_channel) close_frame();
        end
      endcase
    endfunction

    task report(string what, longint got, longint want);
      fails++;
      $display("mismatch on %s: got %0d, want %0d", what, got, want);
    endtask

    task check_frame(mix_frame_t got);
      mix_frame_t want;
      if (frames_due.size() == 0) begin
        report("beat with nothing pending", 1, 0);
        return;
      end
      want = frames_due.pop_front();
      if (got.left_out !== want.left_out) report("left_out", got.left_out, want.left_out);
      if (got.right_out !== want.right_out) report("right_out", got.right_out, want.right_out);
      if (got.chunk_end !== want.chunk_end) report("chunk_end", got.chunk_end, want.chunk_end);
      if (got.active_mask !== want.active_mask)
        report("active_mask", got.active_mask, want.active_mask);
    endtask
  endclass

  logic              clk;
  logic              rst;
  logic              push;
  logic              full;
  logic [1:0]        func;
  logic [CH_W-1:0]   channel;
  logic [SMP_W-1:0]  left_sample;
  logic [SMP_W-1:0]  right_sample;
  logic              last_channel;
  logic [CLIP_W-1:0] clip_length;
  logic [VOL_W-1:0]  volume;
  logic [SEP_W-1:0]  separation;
  logic              empty;
  logic              pop;
  logic [SMP_W-1:0]  left_out;
  logic [SMP_W-1:0]  right_out;
  logic              chunk_end;
  logic [MASK_W-1:0] active_mask;

  mixer_scoreboard sb = new();
  int items_sent  = 0;
  bit hold_off    = 1'b0;
  bit send_quiet  = 1'b0;
  bit recv_quiet  = 1'b0;
  int cycle_count = 0;

  eight_channel_stereo_pcm_mixer_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .channel      (channel),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .last_channel (last_channel),
    .clip_length  (clip_length),
    .volume       (volume),
    .separation   (separation),
    .empty        (empty),
    .pop          (pop),
    .left_out     (left_out),
    .right_out    (right_out),
    .chunk_end    (chunk_end),
    .active_mask  (active_mask)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function logic [SMP_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return SMP_W'(SAMPLE_MID);
      default: return SMP_W'($urandom_range(0, 255));
    endcase
  endfunction

  function logic [CLIP_W-1:0] pick_clip();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return CLIP_W'($urandom_range(0, 700));
    if (r < 65) return CLIP_W'($urandom_range(600, 2000));
    if (r < 85) return CLIP_W'($urandom());
    case ($urandom_range(0, 4))
      0: return '0;
      1: return CLIP_W'(1);
      2: return CLIP_W'(CHUNK_BYTES);
      3: return CLIP_W'(CHUNK_BYTES + 1);
      default: return '1;
    endcase
  endfunction

  function mix_item_t make_item(func_t f, int ch, int l, int r, bit last, int clip,
                                int vol, int sep);
    mix_item_t it;
    it.func         = f;
    it.channel      = CH_W'(ch);
    it.left_sample  = SMP_W'(l);
    it.right_sample = SMP_W'(r);
    it.last_channel = last;
    it.clip_length  = CLIP_W'(clip);
    it.volume       = VOL_W'(vol);
    it.separation   = SEP_W'(sep);
    return it;
  endfunction

  function mix_item_t rand_item();
    mix_item_t it;
    int r;
    it.func         = FUNC_PAIR;
    it.channel      = CH_W'($urandom_range(0, 7));
    it.left_sample  = pick_sample();
    it.right_sample = pick_sample();
    it.last_channel = 1'($urandom_range(0, 1));
    it.clip_length  = pick_clip();
    r = $urandom_range(0, 19);
    it.volume = (r == 0) ? '0 : (r < 3) ? '1 : VOL_W'($urandom_range(0, 127));
    r = $urandom_range(0, 19);
    it.separation = (r < 2) ? SEP_W'(SEP_MAX) : (r == 2) ? '1 : (r == 3) ? '0
                  : SEP_W'($urandom_range(0, 255));
    return it;
  endfunction

  // one beat on the input side, after an optional idle gap
  task offer(mix_item_t it);
    int n;
    n = (send_quiet || hold_off) ? 0 : pick_gap();
    if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
    if (n > 0) begin
      @(negedge clk);
      push <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    push         <= 1'b1;
    func         <= it.func;
    channel      <= it.channel;
    left_sample  <= it.left_sample;
    right_sample <= it.right_sample;
    last_channel <= it.last_channel;
    clip_length  <= it.clip_length;
    volume       <= it.volume;
    separation   <= it.separation;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_item(it);
    items_sent++;
  endtask

  task random_frame();
    mix_item_t it;
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      it = rand_item();
      r  = $urandom_range(0, 9);
      it.func = (r < 5) ? FUNC_START : (r < 7) ? FUNC_STOP : FUNC_UPDATE;
      offer(it);
    end else begin
      // mostly one pair per frame so that a whole chunk goes by within the run
      n = ($urandom_range(0, 99) < 90) ? 1 : $urandom_range(2, 5);
      for (int k = 0; k < n; k++) begin
        it = rand_item();
        it.func = FUNC_PAIR;
        it.last_channel = (k == n - 1);
        offer(it);
      end
    end
  endtask

  // one voice at full gain brings enough pairs to pin a sum at its limit, then pulls it back
  task overflow_frame();
    mix_item_t it;
    int v;
    int k;
    int n;
    bit hi_first;
    v        = $urandom_range(0, 7);
    hi_first = 1'($urandom_range(0, 1));
    it = rand_item();
    it.func        = FUNC_START;
    it.channel     = CH_W'(v);
    it.clip_length = '1;
    it.volume      = '1;
    it.separation  = $urandom_range(0, 1) ? SEP_W'(SEP_MAX) : '0;
    offer(it);
    k = $urandom_range(34, 38);
    n = $urandom_range(31, 34);
    for (int i = 0; i < k + n; i++) begin
      it = rand_item();
      it.func         = FUNC_PAIR;
      it.channel      = CH_W'(v);
      it.left_sample  = ((i < k) == hi_first) ? '1 : '0;
      it.right_sample = it.left_sample;
      it.last_channel = (i == k + n - 1);
      offer(it);
    end
  endtask

  // receiver: random pop gaps, plus one long hold-off while the sender keeps pushing
  initial begin
    int pop_wait;
    mix_frame_t got;
    pop = 1'b0;
    pop_wait = 0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        pop <= 1'b0;
      end else if (pop_wait > 0) begin
        pop <= 1'b0;
        pop_wait--;
      end else begin
        pop <= 1'b1;
      end
      @(posedge clk);
      if (pop && !empty) begin
        got.left_out    = left_out;
        got.right_out   = right_out;
        got.chunk_end   = chunk_end;
        got.active_mask = active_mask;
        sb.check_frame(got);
        pop_wait = recv_quiet ? 0 : pick_gap();
        if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      end
    end
  end

  initial begin
    wait (items_sent >= 250);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int bursts;
    bursts       = 0;
    rst          = 1'b1;
    push         = 1'b0;
    func         = FUNC_PAIR;
    channel      = '0;
    left_sample  = '0;
    right_sample = '0;
    last_channel = 1'b0;
    clip_length  = '0;
    volume       = '0;
    separation   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle mixer gives silence
    offer(make_item(FUNC_PAIR, 5, 255, 0, 1, 0, 0, 0));
    offer(make_item(FUNC_START, 0, 0, 0, 0, 24'hFFFFFF, 127, 254));
    offer(make_item(FUNC_START, 1, 0, 0, 0, 24'hFFFFFF, 127, 0));
    // separation above the maximum, odd clip of one frame
    offer(make_item(FUNC_START, 2, 0, 0, 0, 3, 127, 255));
    // clip too short for any frame
    offer(make_item(FUNC_START, 3, 0, 0, 0, 1, 100, 127));
    offer(make_item(FUNC_PAIR, 0, 255, 0, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 1, 0, 255, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 2, 255, 255, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 3, 0, 0, 1, 0, 0, 0));
    // control beats with last set must not close a frame
    offer(make_item(FUNC_UPDATE, 1, 0, 0, 1, 0, 0, 200));
    offer(make_item(FUNC_STOP, 2, 0, 0, 1, 0, 0, 0));
    offer(make_item(FUNC_START, 7, 0, 0, 1, 0, 127, 127));
    offer(make_item(FUNC_PAIR, 0, 0, 255, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 1, 255, 255, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 2, 255, 0, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 7, 0, 0, 1, 0, 0, 0));
    offer(make_item(FUNC_UPDATE, 0, 0, 0, 0, 0, 127, 127));
    // start in mid chunk counts from the chunk start, so this clip is already spent
    offer(make_item(FUNC_START, 4, 0, 0, 0, 2, 127, 127));
    offer(make_item(FUNC_PAIR, 4, 0, 0, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 0, 128, 128, 0, 0, 0, 0));
    offer(make_item(FUNC_PAIR, 0, 255, 0, 1, 0, 0, 0));
    offer(make_item(FUNC_UPDATE, 5, 0, 0, 0, 0, 127, 255));
    offer(make_item(FUNC_PAIR, 5, 0, 255, 1, 0, 0, 0));

    while (items_sent < 650) begin
      if ((bursts == 0 && items_sent >= 120) || (bursts == 1 && items_sent >= 450)) begin
        overflow_frame();
        bursts++;
      end else begin
        random_frame();
      end
    end

    @(negedge clk);
    push <= 1'b0;
    while (sb.frames_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
